[design/tsr_pkg.sv]
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants of the triangle scanline rasterizer.
// ----------------------------------------------------------------------------
package tsr_pkg;

  // width of the pixel coordinate result fields
  localparam int unsigned PIX_W = 12;

  // request codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ROW,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_FIX,
    ST_FIN
  } back_state_e;

endpackage

[design/triangle_scanline_rasterizer_unit.sv]
// a start request waits in the queue until the walker is back in its idle state
// a next request on the current row or after the walk has ended is answered from check or finish
// rows with sloped edges run mul, divgo and div per edge, then fix; flat edge rows go to fix
// empty rows repeat these steps; the serial divider sets the throughput
// reset: asynchronous, clears the queue, the walk state and the result register
// ----------------------------------------------------------------------------
// triangle_scanline_rasterizer_unit
// Top level: request queue in front, scanline walker with divider behind it.
// ----------------------------------------------------------------------------
module triangle_scanline_rasterizer_unit import tsr_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 4,
  parameter int unsigned COORD_WIDTH     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          action_i,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  input  logic signed [COORD_WIDTH-1:0] third_x_i,
  input  logic signed [COORD_WIDTH-1:0] third_y_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [PIX_W-1:0]       pixel_x_o,
  output logic signed [PIX_W-1:0]       pixel_y_o,
  output logic                          finished_o
);

  logic [6*COORD_WIDTH-1:0] vert, req_vert;
  logic                     req_valid, req_start, req_pop;

  assign vert = {third_y_i, third_x_i, second_y_i, second_x_i, first_y_i, first_x_i};

  tsr_front #(.CW(COORD_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .vert_i      (vert),
    .req_valid_o (req_valid),
    .req_start_o (req_start),
    .req_vert_o  (req_vert),
    .req_pop_i   (req_pop)
  );

  tsr_back #(.CW(COORD_WIDTH), .F(COORD_FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_start_i (req_start),
    .req_vert_i  (req_vert),
    .req_pop_o   (req_pop),
    .empty       (empty),
    .pop         (pop),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .finished_o  (finished_o)
  );

endmodule

[design/tsr_front.sv]
// ----------------------------------------------------------------------------
// tsr_front
// Input side: takes requests into a two-entry queue and tags them as start
// or next for the walker.
// ----------------------------------------------------------------------------
module tsr_front import tsr_pkg::*; #(
  parameter int unsigned CW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              action_i,
  input  logic [6*CW-1:0]   vert_i,
  output logic              req_valid_o,
  output logic              req_start_o,
  output logic [6*CW-1:0]   req_vert_o,
  input  logic              req_pop_i
);

  logic              act_q  [2];
  logic [6*CW-1:0]   vert_q [2];
  logic              wptr_q, rptr_q;
  logic [1:0]        cnt_q;
  logic              do_push, do_pop;

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign req_valid_o = (cnt_q != 2'd0);
  assign do_pop      = req_pop_i && req_valid_o;
  assign req_start_o = (act_q[rptr_q] == ACT_START);
  assign req_vert_o  = vert_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      act_q[wptr_q]  <= action_i;
      vert_q[wptr_q] <= vert_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[design/tsr_div.sv]
// ----------------------------------------------------------------------------
// tsr_div
// Serial floor divider: signed numerator by positive denominator, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsr_div #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic        [DW-1:0] den_i,
  output logic                 done_o,
  output logic signed [NW-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [NW-1:0]    mag_q;
  logic [DW-1:0]    rem_q, den_q;
  logic [DW:0]      rem_sh;
  logic             fit;

  assign rem_sh = {rem_q, mag_q[NW-1]};
  assign fit    = (rem_sh >= {1'b0, den_q});
  assign done_o = busy_q && (cnt_q == '0);
  // round toward minus infinity for a negative numerator
  assign quo_o  = neg_q ? signed'(-mag_q - NW'(rem_q != '0)) : signed'(mag_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1];
      mag_q <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != '0) begin
      mag_q <= {mag_q[NW-2:0], fit};
      rem_q <= fit ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NW);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else             cnt_q  <= cnt_q - 1'b1;
    end
  end

endmodule

[design/tsr_back.sv]
// ----------------------------------------------------------------------------
// tsr_back
// Walker: sorts vertices on start, steps columns and rows, interpolates the
// row crossings with a multiplier and the serial divider, holds the result.
// ----------------------------------------------------------------------------
module tsr_back import tsr_pkg::*; #(
  parameter int unsigned CW = 16,
  parameter int unsigned F  = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  input  logic                    req_start_i,
  input  logic [6*CW-1:0]         req_vert_i,
  output logic                    req_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [PIX_W-1:0] pixel_x_o,
  output logic signed [PIX_W-1:0] pixel_y_o,
  output logic                    finished_o
);

  localparam int unsigned EW = CW + 1;
  localparam int unsigned RW = CW - F + 2;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned MW = (RW > PIX_W) ? RW : PIX_W;
  localparam logic signed [CW:0] ONE_M1 = (CW+1)'((1 << F) - 1);

  back_state_e state_q, state_d;

  logic signed [CW-1:0] v_q [6];
  logic signed [CW-1:0] v_d [6];
  logic signed [RW-1:0] row_q, row_d, col_q, col_d;
  logic signed [CW-1:0] left_q, left_d, right_q, right_d, base_q, base_d;
  logic                 done_q, done_d, pass_q, pass_d;
  logic signed [EW-1:0] opa_q, opa_d, dd_q, dd_d, alt_q, alt_d;
  logic        [EW-1:0] dy_q, dy_d, alt_dy_q, alt_dy_d;
  logic signed [PW-1:0] prod_q;
  logic                 out_valid_q, out_valid_d, out_fin_q, out_fin_d;
  logic signed [RW-1:0] out_x_q, out_x_d, out_y_q, out_y_d;

  logic signed [CW-1:0] rv [6];
  logic signed [CW-1:0] s1 [6];
  logic signed [CW-1:0] s2 [6];
  logic signed [CW-1:0] s3 [6];
  logic signed [CW:0]   ysum, lsum;
  logic signed [RW-1:0] row0, col_ceil;
  logic signed [CW+1:0] ry, colsh;
  logic signed [CW+2:0] d_up, d_dn;
  logic signed [CW-1:0] lo, hi;
  logic signed [EW-1:0] quo_t, sum_t;
  logic                 out_free, div_start, div_done;
  logic signed [PW-1:0] div_quo;
  logic signed [MW-1:0] ox_ext, oy_ext;

  // compare-and-swap sort by y: 1-2, 1-3, 2-3
  always_comb begin
    for (int i = 0; i < 6; i++) rv[i] = signed'(req_vert_i[i*CW +: CW]);
    s1 = rv;
    if (rv[1] > rv[3]) begin
      s1[0] = rv[2]; s1[1] = rv[3]; s1[2] = rv[0]; s1[3] = rv[1];
    end
    s2 = s1;
    if (s1[1] > s1[5]) begin
      s2[0] = s1[4]; s2[1] = s1[5]; s2[4] = s1[0]; s2[5] = s1[1];
    end
    s3 = s2;
    if (s2[3] > s2[5]) begin
      s3[2] = s2[4]; s3[3] = s2[5]; s3[4] = s2[2]; s3[5] = s2[3];
    end
  end

  assign ysum     = (CW+1)'(s3[1]) + ONE_M1;
  assign row0     = RW'(ysum >>> F) - RW'(1);
  assign ry       = (CW+2)'(row_q) <<< F;
  assign colsh    = (CW+2)'(col_q) <<< F;
  assign d_up     = (CW+3)'(ry) - (CW+3)'(v_q[1]);
  assign d_dn     = (CW+3)'(v_q[5]) - (CW+3)'(ry);
  assign lo       = (left_q > right_q) ? right_q : left_q;
  assign hi       = (left_q > right_q) ? left_q : right_q;
  assign lsum     = (CW+1)'(lo) + ONE_M1;
  assign col_ceil = RW'(lsum >>> F);
  assign quo_t    = EW'(div_quo);
  assign sum_t    = EW'(base_q) + quo_t;
  assign out_free = !out_valid_q || pop;

  tsr_div #(.NW(PW), .DW(EW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (dy_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && !req_start_i) state_d = done_q ? ST_FIN : ST_CHECK;
      end
      ST_CHECK: begin
        if (colsh <= right_q) begin
          if (out_free) state_d = ST_IDLE;
        end else begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        if (ry <= v_q[3]) state_d = (v_q[3] == v_q[1]) ? ST_FIX : ST_MUL;
        else if (ry > v_q[5]) state_d = ST_FIN;
        else state_d = (v_q[3] == v_q[5]) ? ST_FIX : ST_MUL;
      end
      ST_MUL:   state_d = ST_DIVGO;
      ST_DIVGO: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = pass_q ? ST_FIX : ST_MUL;
      end
      ST_FIX:   state_d = ST_CHECK;
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    v_d         = v_q;
    row_d       = row_q;
    col_d       = col_q;
    left_d      = left_q;
    right_d     = right_q;
    base_d      = base_q;
    done_d      = done_q;
    pass_d      = pass_q;
    opa_d       = opa_q;
    dd_d        = dd_q;
    alt_d       = alt_q;
    dy_d        = dy_q;
    alt_dy_d    = alt_dy_q;
    out_valid_d = out_valid_q && !pop;
    out_fin_d   = out_fin_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    req_pop_o   = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          if (req_start_i) begin
            v_d     = s3;
            row_d   = row0;
            col_d   = RW'(1);
            left_d  = '0;
            right_d = '0;
            done_d  = 1'b0;
          end else if (!done_q) begin
            col_d = col_q + RW'(1);
          end
        end
      end
      ST_CHECK: begin
        if (colsh <= right_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_fin_d   = 1'b0;
            out_x_d     = col_q;
            out_y_d     = row_q;
          end
        end else begin
          row_d = row_q + RW'(1);
        end
      end
      ST_ROW: begin
        pass_d = 1'b0;
        if (ry <= v_q[3]) begin
          if (v_q[3] == v_q[1]) begin
            left_d  = v_q[0];
            right_d = v_q[2];
          end else begin
            base_d   = v_q[0];
            dd_d     = EW'(d_up);
            opa_d    = EW'(v_q[2]) - EW'(v_q[0]);
            dy_d     = EW'(v_q[3]) - EW'(v_q[1]);
            alt_d    = EW'(v_q[4]) - EW'(v_q[0]);
            alt_dy_d = EW'(v_q[5]) - EW'(v_q[1]);
          end
        end else if (ry > v_q[5]) begin
          done_d = 1'b1;
        end else if (v_q[3] == v_q[5]) begin
          left_d  = v_q[2];
          right_d = v_q[4];
        end else begin
          base_d   = v_q[4];
          dd_d     = EW'(d_dn);
          opa_d    = EW'(v_q[2]) - EW'(v_q[4]);
          dy_d     = EW'(v_q[5]) - EW'(v_q[3]);
          alt_d    = EW'(v_q[0]) - EW'(v_q[4]);
          alt_dy_d = EW'(v_q[5]) - EW'(v_q[1]);
        end
      end
      ST_MUL: ;
      ST_DIVGO: div_start = 1'b1;
      ST_DIV: begin
        if (div_done) begin
          if (pass_q) begin
            right_d = CW'(sum_t);
          end else begin
            left_d = CW'(sum_t);
            opa_d  = alt_q;
            dy_d   = alt_dy_q;
            pass_d = 1'b1;
          end
        end
      end
      ST_FIX: begin
        left_d  = lo;
        right_d = hi;
        col_d   = col_ceil;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_fin_d   = 1'b1;
          out_x_d     = '0;
          out_y_d     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa_q * dd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < 6; i++) v_q[i] <= '0;
      row_q       <= '0;
      col_q       <= RW'(1);
      left_q      <= '0;
      right_q     <= '0;
      base_q      <= '0;
      done_q      <= 1'b0;
      pass_q      <= 1'b0;
      opa_q       <= '0;
      dd_q        <= '0;
      alt_q       <= '0;
      dy_q        <= '0;
      alt_dy_q    <= '0;
      out_valid_q <= 1'b0;
      out_fin_q   <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      v_q         <= v_d;
      row_q       <= row_d;
      col_q       <= col_d;
      left_q      <= left_d;
      right_q     <= right_d;
      base_q      <= base_d;
      done_q      <= done_d;
      pass_q      <= pass_d;
      opa_q       <= opa_d;
      dd_q        <= dd_d;
      alt_q       <= alt_d;
      dy_q        <= dy_d;
      alt_dy_q    <= alt_dy_d;
      out_valid_q <= out_valid_d;
      out_fin_q   <= out_fin_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
    end
  end

  assign ox_ext     = MW'(out_x_q);
  assign oy_ext     = MW'(out_y_q);
  assign empty      = !out_valid_q;
  assign pixel_x_o  = ox_ext[PIX_W-1:0];
  assign pixel_y_o  = oy_ext[PIX_W-1:0];
  assign finished_o = out_fin_q;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the triangle scanline rasterizer against a cycle-free pixel walk
// predictor, with a directed table followed by random triangle walks.
// ----------------------------------------------------------------------------
module tb;
  import tsr_pkg::*;

  localparam int unsigned FRAC  = 4;
  localparam int unsigned CW    = 16;
  localparam longint      ONE   = 64'sd1 << FRAC;
  localparam longint      LIMIT = 3000000;

  typedef struct {
    logic                 act;
    logic signed [CW-1:0] x1, y1, x2, y2, x3, y3;
    bit                   chk;
    logic signed [11:0]   ex, ey;
    logic                 ef;
  } req_t;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic               fin;
  } pix_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic                 action_i = ACT_NEXT;
  logic signed [CW-1:0] first_x_i = '0, first_y_i = '0;
  logic signed [CW-1:0] second_x_i = '0, second_y_i = '0;
  logic signed [CW-1:0] third_x_i = '0, third_y_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic signed [11:0]   pixel_x_o, pixel_y_o;
  logic                 finished_o;

  triangle_scanline_rasterizer_unit #(.COORD_FRAC_BITS(FRAC), .COORD_WIDTH(CW)) u_top (
    .clk_i, .rst_ni, .push, .full, .action_i,
    .first_x_i, .first_y_i, .second_x_i, .second_y_i, .third_x_i, .third_y_i,
    .empty, .pop, .pixel_x_o, .pixel_y_o, .finished_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  req_t   stim_q[$];
  pix_t   pixel_q[$];
  int     errors = 0;
  longint cycles = 0;

  // walker state of the predictor
  longint vtx[6];
  longint w_row, w_col = 1, w_left, w_right;
  bit     w_done;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic void swap_vtx(int i, int j);
    longint tx, ty;
    tx = vtx[2*i]; ty = vtx[2*i+1];
    vtx[2*i] = vtx[2*j]; vtx[2*i+1] = vtx[2*j+1];
    vtx[2*j] = tx; vtx[2*j+1] = ty;
  endfunction

  function automatic bit walk_step(input req_t r, output pix_t p);
    longint ry, d, t;
    p = '{x: '0, y: '0, fin: 1'b1};
    if (r.act == ACT_START) begin
      vtx[0] = r.x1; vtx[1] = r.y1; vtx[2] = r.x2;
      vtx[3] = r.y2; vtx[4] = r.x3; vtx[5] = r.y3;
      if (vtx[1] > vtx[3]) swap_vtx(0, 1);
      if (vtx[1] > vtx[5]) swap_vtx(0, 2);
      if (vtx[3] > vtx[5]) swap_vtx(1, 2);
      w_row = fdiv(vtx[1] + ONE - 1, ONE) - 1;
      w_col = 1; w_left = 0; w_right = 0; w_done = 0;
      return 0;
    end
    if (!w_done) begin
      w_col++;
      while (1) begin
        if (w_col * ONE <= w_right) begin
          p = '{x: w_col[11:0], y: w_row[11:0], fin: 1'b0};
          return 1;
        end
        w_row++;
        ry = w_row * ONE;
        if (ry <= vtx[3]) begin
          if (vtx[3] == vtx[1]) begin
            w_left = vtx[0]; w_right = vtx[2];
          end else begin
            d = ry - vtx[1];
            w_left  = vtx[0] + fdiv((vtx[2] - vtx[0]) * d, vtx[3] - vtx[1]);
            w_right = vtx[0] + fdiv((vtx[4] - vtx[0]) * d, vtx[5] - vtx[1]);
          end
        end else begin
          if (ry > vtx[5]) begin
            w_done = 1;
            break;
          end
          if (vtx[3] == vtx[5]) begin
            w_left = vtx[2]; w_right = vtx[4];
          end else begin
            d = vtx[5] - ry;
            w_left  = vtx[4] + fdiv((vtx[2] - vtx[4]) * d, vtx[5] - vtx[3]);
            w_right = vtx[4] + fdiv((vtx[0] - vtx[4]) * d, vtx[5] - vtx[1]);
          end
        end
        if (w_left > w_right) begin
          t = w_left; w_left = w_right; w_right = t;
        end
        w_col = fdiv(w_left + ONE - 1, ONE);
      end
    end
    p = '{x: '0, y: '0, fin: 1'b1};
    return 1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [CW-1:0] near_coord();
    return CW'($urandom_range(0, 768)) - CW'(384);
  endfunction

  function automatic req_t next_req();
    req_t r;
    r = '{act: ACT_NEXT, x1: $urandom, y1: $urandom, x2: $urandom, y2: $urandom,
          x3: $urandom, y3: $urandom, chk: 0, ex: '0, ey: '0, ef: 1'b0};
    return r;
  endfunction

  // request side
  int  push_gap = 0;
  bit  quiet = 0;
  always @(posedge clk_i) begin
    req_t cur;
    pix_t p;
    if (rst_ni) begin
      cycles++;
      if (push && !full) begin
        cur = stim_q.pop_front();
        if (walk_step(cur, p)) begin
          if (cur.chk) p = '{x: cur.ex, y: cur.ey, fin: cur.ef};
          pixel_q.push_back(p);
        end
        push_gap = quiet ? 0 : pick_gap();
      end
      if ($urandom_range(0, 299) == 0) quiet = !quiet;
      if (push_gap > 0 && !(push && full)) begin
        push_gap--;
        push <= 1'b0;
      end else if (stim_q.size() > 0) begin
        cur = stim_q[0];
        push       <= 1'b1;
        action_i   <= cur.act;
        first_x_i  <= cur.x1; first_y_i  <= cur.y1;
        second_x_i <= cur.x2; second_y_i <= cur.y2;
        third_x_i  <= cur.x3; third_y_i  <= cur.y3;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side
  int pop_gap = 0;
  always @(posedge clk_i) begin
    pix_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pixel_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected pixel x=%0d y=%0d fin=%0b",
                                     pixel_x_o, pixel_y_o, finished_o);
        end else begin
          want = pixel_q.pop_front();
          if (pixel_x_o !== want.x || pixel_y_o !== want.y || finished_o !== want.fin) begin
            errors++;
            if (errors <= 10)
              $display("pixel mismatch: exp x=%0d y=%0d fin=%0b got x=%0d y=%0d fin=%0b",
                       want.x, want.y, want.fin, pixel_x_o, pixel_y_o, finished_o);
          end
        end
        pop_gap = quiet ? 0 : pick_gap();
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  req_t dir_tab[21];
  initial begin
    req_t r;
    int   n_items, n_next, kind;
    dir_tab = '{
      // next straight after reset sees the empty all-zero triangle
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1'b1},
      '{ACT_START, 0, 0, 16, 0, 0, 16, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{ACT_NEXT, -1, -1, -1, -1, -1, -1, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      // flat bottom
      '{ACT_START, 0, 0, -32, 32, 32, 32, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      // flat top at the coordinate extremes
      '{ACT_START, -32768, -32768, 32767, -32768, 0, 32767, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      // unsorted with fractions
      '{ACT_START, 40, 37, -25, -9, 7, 20, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      // degenerate point triangle
      '{ACT_START, 5, 5, 5, 5, 5, 5, 0, 0, 0, 1'b0},
      '{ACT_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0}
    };
    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);

    n_items = 0;
    while (n_items < 1550) begin
      kind = $urandom_range(0, 99);
      r = next_req();
      r.act = ACT_START;
      if (kind < 4) begin
        // wide flat edge near the extremes, only a few pixels
        r.y1 = CW'($urandom); r.y2 = r.y1;
        r.x1 = CW'(-32768 + $urandom_range(0, 255));
        r.x2 = CW'(32767 - $urandom_range(0, 255));
        n_next = $urandom_range(1, 3);
      end else begin
        r.x1 = near_coord(); r.y1 = near_coord();
        r.x2 = near_coord(); r.y2 = near_coord();
        r.x3 = near_coord(); r.y3 = near_coord();
        if (kind < 15) r.y2 = r.y1;
        else if (kind < 25) r.y3 = r.y2;
        n_next = (kind < 90) ? $urandom_range(1, 40) : $urandom_range(0, 3);
      end
      stim_q.push_back(r);
      n_items++;
      repeat (n_next) begin
        stim_q.push_back(next_req());
        n_items++;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_q.size() == 0);
    wait (pixel_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
design/tsr_pkg.sv
design/tsr_front.sv
design/tsr_div.sv
design/tsr_back.sv
design/triangle_scanline_rasterizer_unit.sv
dv/tb.sv
